// ----- sv/bvu_pkg.sv -----
// Package for the brick volume unpacker: field widths, register indexes,
// the configuration bundle and saturation limits. No dependencies.
package bvu_pkg;

  localparam int EXT_W      = 10;  // extent registers
  localparam int OFF_W      = 16;  // byte offset
  localparam int SCL_W      = 24;  // Q8.16 scale
  localparam int RAW_W      = 8;
  localparam int ADDR_W     = 27;
  localparam int DENS_W     = 32;
  localparam int NB_W       = 8;   // bricks per axis, at most 128
  localparam int EXY_W      = 2 * EXT_W;
  localparam int DIFF_W     = OFF_W + 1;
  localparam int PROD_W     = DIFF_W + SCL_W;
  localparam int CIDX_W     = 3;
  localparam int CDATA_W    = 24;
  localparam int BYTE_W     = 9;   // byte position inside a 512 byte brick
  localparam int EXT_LIMIT  = (1 << EXT_W) - 1;

  localparam logic [EXT_W-1:0]  EXT_RST   = EXT_W'(1);
  localparam logic [OFF_W-1:0]  OFF_RST   = '0;
  localparam logic [SCL_W-1:0]  SCL_RST   = SCL_W'(65536);
  localparam logic [DENS_W-1:0] DENS_MAX  = {1'b0, {(DENS_W-1){1'b1}}};
  localparam logic [DENS_W-1:0] DENS_MIN  = {1'b1, {(DENS_W-1){1'b0}}};

  typedef enum logic [CIDX_W-1:0] {
    REG_EXTENT_X     = 3'd0,
    REG_EXTENT_Y     = 3'd1,
    REG_EXTENT_Z     = 3'd2,
    REG_BYTE_OFFSET  = 3'd3,
    REG_SCALE_FACTOR = 3'd4
  } reg_idx_e;

  // Effective (clamped) configuration as seen by the datapath
  typedef struct packed {
    logic [EXT_W-1:0] ex;
    logic [EXT_W-1:0] ey;
    logic [EXT_W-1:0] ez;
    logic [NB_W-1:0]  nbx;
    logic [NB_W-1:0]  nby;
    logic [NB_W-1:0]  nbz;
    logic [OFF_W-1:0] offset;
    logic [SCL_W-1:0] scale;
    logic [EXY_W-1:0] exy;
  } cfg_t;

endpackage

// ----- sv/brick_volume_unpacker.sv -----
// Brick volume unpacker top level: config block, brick walker and result
// pipeline. Uses bvu_pkg, bvu_cfg, bvu_walk, bvu_math.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   raw_byte_i
//   out      output     out_valid_o / out_stall_i voxel_address_o, density_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte per cycle while not stalled; a voxel result is valid after its byte
// passes the input register, multiply stage and output register. Padding
// bytes advance the walker and give nothing. Reset clears the counters and
// loads the register defaults; the config port is always ready. An output
// stall backs up through the three stages before in_stall_o rises.
module brick_volume_unpacker #(
  parameter int MAX_EXTENT = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bvu_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [bvu_pkg::CDATA_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bvu_pkg::RAW_W-1:0]   raw_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bvu_pkg::ADDR_W-1:0]  voxel_address_o,
  output logic [bvu_pkg::DENS_W-1:0]  density_o
);
  import bvu_pkg::*;

  localparam int EXT_CAP = (MAX_EXTENT < EXT_LIMIT) ? MAX_EXTENT : EXT_LIMIT;
  localparam int NB_MAX  = (EXT_CAP + 7) / 8;
  localparam int BW      = (NB_MAX > 1) ? $clog2(NB_MAX) : 1;
  localparam int CW      = BW + 3;

  cfg_t          cfg;
  logic [CW-1:0] gx, gy, gz;
  logic          hit, accept;

  assign accept = in_valid_i && !in_stall_o;

  bvu_cfg #(
    .MAX_EXTENT(MAX_EXTENT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bvu_walk #(
    .BW(BW)
  ) u_walk (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .adv_i (accept),
    .gx_o  (gx),
    .gy_o  (gy),
    .gz_o  (gz),
    .hit_o (hit)
  );

  bvu_math #(
    .CW(CW)
  ) u_math (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_byte_i     (raw_byte_i),
    .gx_i           (gx),
    .gy_i           (gy),
    .gz_i           (gz),
    .hit_i          (hit),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .voxel_address_o(voxel_address_o),
    .density_o      (density_o)
  );

  // input backs up only when the output is full and blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with output free");

  // walker position moves only on an accepted item
  a_walk_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(gx) && $stable(gy) && $stable(gz)))
    else $error("walker moved without an accepted item");

  // a stalled result keeps its address until taken
  a_addr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(voxel_address_o)))
    else $error("stalled result changed");

endmodule

// ----- sv/bvu_cfg.sv -----
// Configuration registers of the brick volume unpacker, extent clamping,
// brick counts per axis and the registered x*y plane size. Uses bvu_pkg.
module bvu_cfg #(
  parameter int MAX_EXTENT = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bvu_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [bvu_pkg::CDATA_W-1:0] cfg_data_i,
  output bvu_pkg::cfg_t               cfg_o
);
  import bvu_pkg::*;

  localparam int EXT_CAP = (MAX_EXTENT < EXT_LIMIT) ? MAX_EXTENT : EXT_LIMIT;

  logic [EXT_W-1:0] ext_x_q, ext_y_q, ext_z_q;
  logic [OFF_W-1:0] offset_q;
  logic [SCL_W-1:0] scale_q;
  logic [EXY_W-1:0] exy_q;
  logic [EXT_W-1:0] ex, ey, ez;
  logic             wr;

  function automatic logic [EXT_W-1:0] eff_ext(input logic [EXT_W-1:0] e);
    logic [EXT_W-1:0] r;
    r = e;
    if (e == '0) begin
      r = EXT_W'(1);
    end else if (int'(e) > EXT_CAP) begin
      r = EXT_W'(EXT_CAP);
    end
    return r;
  endfunction

  function automatic logic [NB_W-1:0] brick_cnt(input logic [EXT_W-1:0] e);
    logic [EXT_W:0] s;
    s = {1'b0, e} + (EXT_W + 1)'(7);
    return NB_W'(s[EXT_W:3]);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_x_q  <= EXT_RST;
      ext_y_q  <= EXT_RST;
      ext_z_q  <= EXT_RST;
      offset_q <= OFF_RST;
      scale_q  <= SCL_RST;
    end else if (wr) begin
      case (reg_idx_e'(cfg_index_i))
        REG_EXTENT_X:     ext_x_q  <= cfg_data_i[EXT_W-1:0];
        REG_EXTENT_Y:     ext_y_q  <= cfg_data_i[EXT_W-1:0];
        REG_EXTENT_Z:     ext_z_q  <= cfg_data_i[EXT_W-1:0];
        REG_BYTE_OFFSET:  offset_q <= cfg_data_i[OFF_W-1:0];
        REG_SCALE_FACTOR: scale_q  <= cfg_data_i[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  assign ex = eff_ext(ext_x_q);
  assign ey = eff_ext(ext_y_q);
  assign ez = eff_ext(ext_z_q);

  // plane size is registered after the extents; only used past the first stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exy_q <= EXY_W'(1);
    end else begin
      exy_q <= ex * ey;
    end
  end

  always_comb begin
    cfg_o.ex     = ex;
    cfg_o.ey     = ey;
    cfg_o.ez     = ez;
    cfg_o.nbx    = brick_cnt(ex);
    cfg_o.nby    = brick_cnt(ey);
    cfg_o.nbz    = brick_cnt(ez);
    cfg_o.offset = offset_q;
    cfg_o.scale  = scale_q;
    cfg_o.exy    = exy_q;
  end

endmodule

// ----- sv/bvu_walk.sv -----
// Brick walker: byte and brick counters, grid coordinates of the current
// byte and the inside-extent test. Uses bvu_pkg.
module bvu_walk #(
  parameter int BW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bvu_pkg::cfg_t cfg_i,
  input  logic          adv_i,
  output logic [BW+2:0] gx_o,
  output logic [BW+2:0] gy_o,
  output logic [BW+2:0] gz_o,
  output logic          hit_o
);
  import bvu_pkg::*;

  localparam int CW    = BW + 3;
  localparam int CMP_W = (CW > EXT_W) ? CW : EXT_W;
  localparam int AW    = (BW + 1 > NB_W) ? BW + 1 : NB_W;

  logic [BYTE_W-1:0] byte_q, byte_d, pos;
  logic [BW-1:0]     col_q, col_d, row_q, row_d, lay_q, lay_d;
  logic [AW-1:0]     col_inc, row_inc, lay_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      lay_q  <= '0;
    end else begin
      byte_q <= byte_d;
      col_q  <= col_d;
      row_q  <= row_d;
      lay_q  <= lay_d;
    end
  end

  assign col_inc = AW'(col_q) + AW'(1);
  assign row_inc = AW'(row_q) + AW'(1);
  assign lay_inc = AW'(lay_q) + AW'(1);

  always_comb begin
    byte_d = byte_q;
    col_d  = col_q;
    row_d  = row_q;
    lay_d  = lay_q;
    if (adv_i) begin
      byte_d = byte_q + BYTE_W'(1);
      if (&byte_q) begin
        // counters left beyond a shrunk count fall through to zero here
        if (col_inc < AW'(cfg_i.nbx)) begin
          col_d = BW'(col_inc);
        end else begin
          col_d = '0;
          if (row_inc < AW'(cfg_i.nby)) begin
            row_d = BW'(row_inc);
          end else begin
            row_d = '0;
            if (lay_inc < AW'(cfg_i.nbz)) begin
              lay_d = BW'(lay_inc);
            end else begin
              lay_d = '0;
            end
          end
        end
      end
    end
  end

  // bytes are pair-swapped inside a brick
  assign pos  = byte_q ^ BYTE_W'(1);
  assign gx_o = {col_q, pos[2:0]};
  assign gy_o = {row_q, pos[5:3]};
  assign gz_o = {lay_q, pos[8:6]};

  assign hit_o = (CMP_W'(gx_o) < CMP_W'(cfg_i.ex)) &&
                 (CMP_W'(gy_o) < CMP_W'(cfg_i.ey)) &&
                 (CMP_W'(gz_o) < CMP_W'(cfg_i.ez));

endmodule

// ----- sv/bvu_math.sv -----
// Result pipeline: input register, multiply stage (address terms and
// density product), output register with add and saturation. Uses bvu_pkg.
module bvu_math #(
  parameter int CW = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bvu_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bvu_pkg::RAW_W-1:0]  raw_byte_i,
  input  logic [CW-1:0]              gx_i,
  input  logic [CW-1:0]              gy_i,
  input  logic [CW-1:0]              gz_i,
  input  logic                       hit_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bvu_pkg::ADDR_W-1:0] voxel_address_o,
  output logic [bvu_pkg::DENS_W-1:0] density_o
);
  import bvu_pkg::*;

  localparam int PY_W = CW + EXT_W;
  localparam int PZ_W = CW + EXY_W;

  logic              v1_q, v2_q, vo_q;
  logic              rdy1, rdy2, rdyo;
  logic [RAW_W-1:0]  raw1_q;
  logic [CW-1:0]     gx1_q, gy1_q, gz1_q, gx2_q;
  logic [ADDR_W-1:0] py2_q, pz2_q, addr_q;
  logic [PY_W-1:0]   py;
  logic [PZ_W-1:0]   pz;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SCL_W-1:0]  scale;
  logic signed [PROD_W-1:0] prod, prod2_q;
  logic [DENS_W-1:0] dens_q, dens_sat;

  assign rdyo       = !vo_q || !out_stall_i;
  assign rdy2       = !v2_q || rdyo;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i && hit_i;  // padding voxels drop here
      if (rdy2) v2_q <= v1_q;
      if (rdyo) vo_q <= v2_q;
    end
  end

  // stage 1: item register
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      raw1_q <= raw_byte_i;
      gx1_q  <= gx_i;
      gy1_q  <= gy_i;
      gz1_q  <= gz_i;
    end
  end

  // stage 2: multiplies
  assign py    = gy1_q * cfg_i.ex;
  assign pz    = gz1_q * cfg_i.exy;
  assign diff  = $signed({{(DIFF_W-RAW_W){1'b0}}, raw1_q})
               - $signed({cfg_i.offset[OFF_W-1], cfg_i.offset});
  assign scale = $signed(cfg_i.scale);
  assign prod  = diff * scale;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      gx2_q   <= gx1_q;
      py2_q   <= ADDR_W'(py);
      pz2_q   <= ADDR_W'(pz);
      prod2_q <= prod;
    end
  end

  // output stage: address sum and clamp to Q16.16
  always_comb begin
    if (prod2_q[PROD_W-1:DENS_W-1] == '0 || prod2_q[PROD_W-1:DENS_W-1] == '1) begin
      dens_sat = prod2_q[DENS_W-1:0];
    end else if (prod2_q[PROD_W-1]) begin
      dens_sat = DENS_MIN;
    end else begin
      dens_sat = DENS_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdyo) begin
      addr_q <= ADDR_W'(gx2_q) + py2_q + pz2_q;
      dens_q <= dens_sat;
    end
  end

  assign out_valid_o     = vo_q;
  assign voxel_address_o = addr_q;
  assign density_o       = dens_q;

endmodule

// ----- verif/tb_brick_volume_unpacker.sv -----
// Self-checking testbench for brick_volume_unpacker: byte stream in, voxel
// results out, checked in order against a brick-walk predictor kept here.
// Depends on bvu_pkg and the brick_volume_unpacker RTL.
module tb_brick_volume_unpacker;
  import bvu_pkg::*;

  localparam int MAX_EXTENT       = 512;
  localparam int DIRECTED_PER_SET = 8;
  localparam int RANDOM_ITEMS     = 1550;
  localparam int SETTLE_CYCLES    = 12;
  localparam int CYCLE_LIMIT      = 400000;

  // indexes past the register list; writes there are dropped
  localparam logic [CIDX_W-1:0] CFG_IDX_SPARE_LO = CIDX_W'(5);
  localparam logic [CIDX_W-1:0] CFG_IDX_SPARE_HI = CIDX_W'(7);

  localparam longint DENS_HI = longint'($signed(DENS_MAX));
  localparam longint DENS_LO = longint'($signed(DENS_MIN));

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [DENS_W-1:0] density;
  } voxel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_valid = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;
  logic               cfg_ready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [RAW_W-1:0]   raw_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ADDR_W-1:0]  voxel_address;
  logic [DENS_W-1:0]  density;

  // predictor copy of the registers and the brick walk
  logic [EXT_W-1:0]        extent_x_q = EXT_RST;
  logic [EXT_W-1:0]        extent_y_q = EXT_RST;
  logic [EXT_W-1:0]        extent_z_q = EXT_RST;
  logic signed [OFF_W-1:0] offset_q = OFF_RST;
  logic signed [SCL_W-1:0] scale_q = SCL_RST;
  logic [BYTE_W-1:0]       byte_pos = '0;
  int unsigned             brick_x = 0;
  int unsigned             brick_y = 0;
  int unsigned             brick_z = 0;

  logic [RAW_W-1:0] pending_bytes[$];
  voxel_t           expected_voxels[$];
  int               mismatches = 0;
  int               cycle_count = 0;

  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left = 0;

  brick_volume_unpacker #(
    .MAX_EXTENT(MAX_EXTENT)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .raw_byte_i     (raw_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .voxel_address_o(voxel_address),
    .density_o      (density)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int unsigned clamp_extent(logic [EXT_W-1:0] e);
    if (e == 0) return 1;
    if (e > MAX_EXTENT) return MAX_EXTENT;
    return e;
  endfunction

  function automatic void predict_voxel(logic [RAW_W-1:0] raw);
    int unsigned ex, ey, ez, nbx, nby, nbz, gx, gy, gz;
    logic [BYTE_W-1:0] pos;
    longint addr, prod;
    voxel_t v;
    ex = clamp_extent(extent_x_q);
    ey = clamp_extent(extent_y_q);
    ez = clamp_extent(extent_z_q);
    nbx = (ex + 7) / 8;
    nby = (ey + 7) / 8;
    nbz = (ez + 7) / 8;
    pos = byte_pos ^ BYTE_W'(1);  // bytes arrive pair-swapped
    gx = brick_x * 8 + pos[2:0];
    gy = brick_y * 8 + pos[5:3];
    gz = brick_z * 8 + pos[8:6];
    if (gx < ex && gy < ey && gz < ez) begin
      addr = longint'(gx) + longint'(gy) * ex + longint'(gz) * ex * ey;
      prod = (longint'(raw) - longint'(offset_q)) * longint'(scale_q);
      if (prod > DENS_HI) prod = DENS_HI;
      if (prod < DENS_LO) prod = DENS_LO;
      v.address = addr[ADDR_W-1:0];
      v.density = prod[DENS_W-1:0];
      expected_voxels.push_back(v);
    end
    byte_pos = byte_pos + 1'b1;
    if (byte_pos == 0) begin
      // counters left past the end by a register change wrap here too
      brick_x++;
      if (brick_x >= nbx) begin
        brick_x = 0;
        brick_y++;
        if (brick_y >= nby) begin
          brick_y = 0;
          brick_z++;
          if (brick_z >= nbz) brick_z = 0;
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_EXTENT_X:     extent_x_q = data[EXT_W-1:0];
      REG_EXTENT_Y:     extent_y_q = data[EXT_W-1:0];
      REG_EXTENT_Z:     extent_z_q = data[EXT_W-1:0];
      REG_BYTE_OFFSET:  offset_q   = data[OFF_W-1:0];
      REG_SCALE_FACTOR: scale_q    = data[SCL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // upper data bits are junk the block must drop
  task automatic apply_settings(input int ex, input int ey, input int ez,
                                input int off, input int scl);
    logic [CDATA_W-1:0] junk;
    junk = CDATA_W'($urandom);
    write_reg(REG_EXTENT_X, {junk[CDATA_W-1:EXT_W], ex[EXT_W-1:0]});
    write_reg(REG_EXTENT_Y, {junk[EXT_W-1:0], junk[CDATA_W-1:2*EXT_W], ey[EXT_W-1:0]});
    write_reg(REG_EXTENT_Z, {junk[CDATA_W-EXT_W-1:0], ez[EXT_W-1:0]});
    write_reg(REG_BYTE_OFFSET, {junk[CDATA_W-1:OFF_W], off[OFF_W-1:0]});
    write_reg(REG_SCALE_FACTOR, scl[SCL_W-1:0]);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_voxels.size() != 0);
    // padding items may still be in flight with nothing expected
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int pick_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 6) return MAX_EXTENT;
    if (r < 8) return EXT_LIMIT;
    if (r < 10) return $urandom_range(MAX_EXTENT + 1, EXT_LIMIT - 1);
    if (r < 60) return $urandom_range(1, 8);
    return $urandom_range(9, 24);
  endfunction

  // item driver: bursts of random length, random gaps in between
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      raw_byte   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        in_valid <= 1'b1;
        raw_byte <= pending_bytes.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall pattern, switching to a random mode when the mode counter runs out
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode <= STALL_NONE;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((mode_left % 8) < 3);
      endcase
    end
  end

  always @(posedge clk) begin : voxel_monitor
    voxel_t want;
    if (rst_n && in_valid && !in_stall) predict_voxel(raw_byte);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_voxels.size() == 0) begin
        report_mismatch($sformatf("unexpected voxel, address %0d density %h",
                                  voxel_address, density));
      end else begin
        want = expected_voxels.pop_front();
        if (voxel_address !== want.address)
          report_mismatch($sformatf("address %0d, want %0d", voxel_address, want.address));
        if (density !== want.density)
          report_mismatch($sformatf("density %h at address %0d, want %h",
                                    density, want.address, want.density));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    logic [RAW_W-1:0] directed_bytes[3*DIRECTED_PER_SET];
    int sent, n, off, scl, r;
    directed_bytes = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h80, 8'h7F,
                       8'h02, 8'hFD, 8'h04, 8'hFB, 8'h08, 8'hF7, 8'h10, 8'hEF,
                       8'h20, 8'hDF, 8'h40, 8'hBF, 8'h00, 8'hFF, 8'h33, 8'hCC};
    wait (rst_n === 1'b1);
    @(negedge clk);

    // directed: zero extent, extent above max, both saturation limits
    write_reg(CFG_IDX_SPARE_LO, 24'hABCDEF);
    for (int s = 0; s < 3; s++) begin
      case (s)
        0: apply_settings(8, 8, 0, 0, 65536);
        1: apply_settings(EXT_LIMIT, 8, 8, -32768, 8388607);
        default: apply_settings(8, 8, 8, 32767, 8388607);
      endcase
      for (int i = 0; i < DIRECTED_PER_SET; i++)
        pending_bytes.push_back(directed_bytes[s * DIRECTED_PER_SET + i]);
      wait_drained();
    end

    // random phases: fresh settings, then a stretch of the brick stream
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0)
        write_reg(CIDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                  CDATA_W'($urandom));
      r = $urandom_range(0, 99);
      if (r < 5)       off = -32768;
      else if (r < 10) off = 32767;
      else if (r < 70) off = $urandom_range(0, 255);
      else             off = $signed(16'($urandom));
      r = $urandom_range(0, 99);
      if (r < 5)       scl = -8388608;
      else if (r < 10) scl = 8388607;
      else if (r < 15) scl = 0;
      else if (r < 20) scl = 65536;
      else if (r < 60) scl = $urandom_range(0, 1 << 19) - (1 << 18);
      else             scl = $signed(24'($urandom));
      apply_settings(pick_extent(), pick_extent(), pick_extent(), off, scl);
      n = $urandom_range(40, 260);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      repeat (n) begin
        if ($urandom_range(0, 9) == 0)
          pending_bytes.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
        else
          pending_bytes.push_back(RAW_W'($urandom));
      end
      sent += n;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
